[design/avd_pkg.sv]
// Shared types, codes and tables for the ADPCM voice decoder.
package avd_pkg;

    localparam int SIGNAL_W  = 12;
    localparam int STEP_W    = 6;
    localparam int STEP_MAX  = 48;
    localparam int CODE_W    = 4;
    localparam int SELECT_W  = 4;
    localparam int STEPVAL_W = 11;

    localparam logic signed [SIGNAL_W-1:0] SIGNAL_MAX = 12'sd2047;
    localparam logic signed [SIGNAL_W-1:0] SIGNAL_MIN = -12'sd2048;

    typedef enum logic [2:0] {
        MODE_DATA     = 3'd0,
        MODE_RESET    = 3'd1,
        MODE_CLOCK    = 3'd2,
        MODE_PLAYMODE = 3'd3,
        MODE_TICK     = 3'd4
    } item_mode_t;

    // Step size for each step index: floor(16 * 1.1^n).
    function automatic logic [STEPVAL_W-1:0] step_size(input logic [STEP_W-1:0] idx);
        logic [STEPVAL_W-1:0] v;
        begin
            case (idx)
                6'd0:  v = 11'd16;
                6'd1:  v = 11'd17;
                6'd2:  v = 11'd19;
                6'd3:  v = 11'd21;
                6'd4:  v = 11'd23;
                6'd5:  v = 11'd25;
                6'd6:  v = 11'd28;
                6'd7:  v = 11'd31;
                6'd8:  v = 11'd34;
                6'd9:  v = 11'd37;
                6'd10: v = 11'd41;
                6'd11: v = 11'd45;
                6'd12: v = 11'd50;
                6'd13: v = 11'd55;
                6'd14: v = 11'd60;
                6'd15: v = 11'd66;
                6'd16: v = 11'd73;
                6'd17: v = 11'd80;
                6'd18: v = 11'd88;
                6'd19: v = 11'd97;
                6'd20: v = 11'd107;
                6'd21: v = 11'd118;
                6'd22: v = 11'd130;
                6'd23: v = 11'd143;
                6'd24: v = 11'd157;
                6'd25: v = 11'd173;
                6'd26: v = 11'd190;
                6'd27: v = 11'd209;
                6'd28: v = 11'd230;
                6'd29: v = 11'd253;
                6'd30: v = 11'd279;
                6'd31: v = 11'd307;
                6'd32: v = 11'd337;
                6'd33: v = 11'd371;
                6'd34: v = 11'd408;
                6'd35: v = 11'd449;
                6'd36: v = 11'd494;
                6'd37: v = 11'd544;
                6'd38: v = 11'd598;
                6'd39: v = 11'd658;
                6'd40: v = 11'd724;
                6'd41: v = 11'd796;
                6'd42: v = 11'd876;
                6'd43: v = 11'd963;
                6'd44: v = 11'd1060;
                6'd45: v = 11'd1166;
                6'd46: v = 11'd1282;
                6'd47: v = 11'd1411;
                default: v = 11'd1552;
            endcase
            return v;
        end
    endfunction

    // Step index adjustment for the magnitude bits of a code.
    function automatic logic signed [4:0] step_adjust(input logic [2:0] mag);
        logic signed [4:0] a;
        begin
            case (mag)
                3'd4:    a = 5'sd2;
                3'd5:    a = 5'sd4;
                3'd6:    a = 5'sd6;
                3'd7:    a = 5'sd8;
                default: a = -5'sd1;
            endcase
            return a;
        end
    endfunction

    // Prescaler is zero only for play selects 3 and 7.
    function automatic logic prescaler_zero(input logic [SELECT_W-1:0] sel);
        return (sel[3] == 1'b0) && (sel[1:0] == 2'b11);
    endfunction

endpackage

[design/avd_step.sv]
// One decoder clock: table difference, saturating add and step index clamp, or both cleared while reset_pin is high.
module avd_step (
    input  logic [avd_pkg::CODE_W-1:0]          code,
    input  logic                                reset_pin,
    input  logic signed [avd_pkg::SIGNAL_W-1:0] sample,
    input  logic [avd_pkg::STEP_W-1:0]          step,
    output logic signed [avd_pkg::SIGNAL_W-1:0] sample_next,
    output logic [avd_pkg::STEP_W-1:0]          step_next
);

    logic [avd_pkg::STEPVAL_W-1:0]  sv;
    logic [avd_pkg::STEPVAL_W+1:0]  mag;
    logic signed [avd_pkg::SIGNAL_W+2:0] sum;
    logic signed [4:0]                   adj;
    logic signed [avd_pkg::STEP_W+1:0]   st;

    always_comb
    begin
        sv  = avd_pkg::step_size(step);
        mag = {5'b00000, sv[avd_pkg::STEPVAL_W-1:3]};
        if (code[2])
        begin
            mag = mag + {2'b00, sv};
        end
        if (code[1])
        begin
            mag = mag + {3'b000, sv[avd_pkg::STEPVAL_W-1:1]};
        end
        if (code[0])
        begin
            mag = mag + {4'b0000, sv[avd_pkg::STEPVAL_W-1:2]};
        end

        if (code[3])
        begin
            sum = {{3{sample[avd_pkg::SIGNAL_W-1]}}, sample} - $signed({2'b00, mag});
        end
        else
        begin
            sum = {{3{sample[avd_pkg::SIGNAL_W-1]}}, sample} + $signed({2'b00, mag});
        end

        adj = avd_pkg::step_adjust(code[2:0]);
        st  = $signed({2'b00, step}) + $signed({{3{adj[4]}}, adj});

        if (reset_pin)
        begin
            sample_next = '0;
            step_next   = '0;
        end
        else
        begin
            if (sum > $signed({{3{avd_pkg::SIGNAL_MAX[avd_pkg::SIGNAL_W-1]}},
                               avd_pkg::SIGNAL_MAX}))
            begin
                sample_next = avd_pkg::SIGNAL_MAX;
            end
            else if (sum < $signed({{3{avd_pkg::SIGNAL_MIN[avd_pkg::SIGNAL_W-1]}},
                                    avd_pkg::SIGNAL_MIN}))
            begin
                sample_next = avd_pkg::SIGNAL_MIN;
            end
            else
            begin
                sample_next = sum[avd_pkg::SIGNAL_W-1:0];
            end

            if (st > (avd_pkg::STEP_W+2)'(avd_pkg::STEP_MAX))
            begin
                step_next = avd_pkg::STEP_W'(avd_pkg::STEP_MAX);
            end
            else if (st < 0)
            begin
                step_next = '0;
            end
            else
            begin
                step_next = st[avd_pkg::STEP_W-1:0];
            end
        end
    end

endmodule

[design/adpcm_voice_decoder_unit.sv]
// ADPCM voice decoder top level: input register, item control, result register.
// An accepted item passes through the input register and then the result register,
// where it waits while m_tready is low.
// Throughput: one item per cycle while the output is not stalled; the decoder update
// is a single table lookup, saturating add and clamp between the two registers.
// Reset (rst_n low, asynchronous) clears the valid flags of both stages and the decoder state;
// the play mode returns to 0 until the configuration register is written or a play mode item arrives.
module adpcm_voice_decoder_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [3:0]  cfg_wdata,      // initial_playmode
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,        // [3:0] data_nibble, [4] pin_level, [8:5] play_select
    input  logic [2:0]  s_tuser,        // [2:0] mode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,        // [11:0] signal, [17:12] step_index
    output logic [1:0]  m_tuser         // [0] decoded, [1] signal_changed
);

    localparam int SW = avd_pkg::SIGNAL_W;
    localparam int TW = avd_pkg::STEP_W;

    // Input stage
    logic                             in_valid_reg;
    logic [2:0]                       in_mode_reg;
    logic [avd_pkg::CODE_W-1:0]       in_nibble_reg;
    logic                             in_level_reg;
    logic [avd_pkg::SELECT_W-1:0]     in_select_reg;

    // Decoder state
    logic [avd_pkg::CODE_W-1:0]       code_reg, code_next;
    logic                             clock_pin_reg, clock_pin_next;
    logic                             reset_pin_reg, reset_pin_next;
    logic [avd_pkg::SELECT_W-1:0]     mode_select_reg, mode_select_next;
    logic signed [SW-1:0]             sample_reg, sample_next;
    logic [TW-1:0]                    step_reg, step_next;

    // Result stage
    logic                             out_valid_reg;
    logic signed [SW-1:0]             out_signal_reg;
    logic [TW-1:0]                    out_step_reg;
    logic                             out_decoded_reg;
    logic                             out_changed_reg;

    logic                             advance;
    logic                             clocked;
    logic signed [SW-1:0]             dec_sample;
    logic [TW-1:0]                    dec_step;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    avd_step u_step (
        .code        (code_reg),
        .reset_pin   (reset_pin_reg),
        .sample      (sample_reg),
        .step        (step_reg),
        .sample_next (dec_sample),
        .step_next   (dec_step)
    );

    always_comb
    begin
        code_next        = code_reg;
        clock_pin_next   = clock_pin_reg;
        reset_pin_next   = reset_pin_reg;
        mode_select_next = mode_select_reg;
        clocked          = 1'b0;
        case (in_mode_reg)
            avd_pkg::MODE_DATA:
            begin
                // In 3-bit mode the code sits one bit up.
                if (mode_select_reg[2])
                begin
                    code_next = in_nibble_reg;
                end
                else
                begin
                    code_next = {in_nibble_reg[2:0], 1'b0};
                end
            end
            avd_pkg::MODE_RESET:
            begin
                reset_pin_next = in_level_reg;
            end
            avd_pkg::MODE_CLOCK:
            begin
                // The external clock only counts while the prescaler is zero.
                if (avd_pkg::prescaler_zero(mode_select_reg) &&
                    (clock_pin_reg != in_level_reg))
                begin
                    clock_pin_next = in_level_reg;
                    clocked        = !in_level_reg;
                end
            end
            avd_pkg::MODE_PLAYMODE:
            begin
                mode_select_next = in_select_reg;
            end
            avd_pkg::MODE_TICK:
            begin
                clocked = !avd_pkg::prescaler_zero(mode_select_reg);
            end
            default:
            begin
                clocked = 1'b0;
            end
        endcase
        sample_next = clocked ? dec_sample : sample_reg;
        step_next   = clocked ? dec_step : step_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_mode_reg   <= s_tuser;
            in_nibble_reg <= s_tdata[3:0];
            in_level_reg  <= s_tdata[4];
            in_select_reg <= s_tdata[8:5];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            code_reg        <= '0;
            clock_pin_reg   <= 1'b0;
            reset_pin_reg   <= 1'b0;
            mode_select_reg <= '0;
            sample_reg      <= '0;
            step_reg        <= '0;
        end
        else if (cfg_we)
        begin
            mode_select_reg <= cfg_wdata;
        end
        else if (advance)
        begin
            code_reg        <= code_next;
            clock_pin_reg   <= clock_pin_next;
            reset_pin_reg   <= reset_pin_next;
            mode_select_reg <= mode_select_next;
            sample_reg      <= sample_next;
            step_reg        <= step_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_signal_reg  <= sample_next;
            out_step_reg    <= step_next;
            out_decoded_reg <= clocked;
            out_changed_reg <= (sample_next != sample_reg);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b0, out_step_reg, out_signal_reg};
    assign m_tuser  = {out_changed_reg, out_decoded_reg};

endmodule
